@@ design/rpn_pkg.sv @@
package rpn_pkg;

    localparam int DEPTH  = 16;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int DATA_W = 32;
    localparam int ACT_W  = 3;
    localparam int ST_W   = 3;

    localparam logic [ACT_W-1:0] ACT_PUSH = 3'd0;
    localparam logic [ACT_W-1:0] ACT_ADD  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_SUB  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_MUL  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_DIV  = 3'd4;
    localparam logic [ACT_W-1:0] ACT_PEEK = 3'd5;
    localparam logic [ACT_W-1:0] ACT_DUMP = 3'd6;

    localparam logic [ST_W-1:0] ST_OK      = 3'd0;
    localparam logic [ST_W-1:0] ST_EMPTY   = 3'd1;
    localparam logic [ST_W-1:0] ST_ONE     = 3'd2;
    localparam logic [ST_W-1:0] ST_FULL    = 3'd3;
    localparam logic [ST_W-1:0] ST_DIVZERO = 3'd4;

    typedef enum logic [2:0] {
        VSEL_ZERO,
        VSEL_TOP,
        VSEL_OPND,
        VSEL_ALU,
        VSEL_QUO
    } vsel_t;

    typedef struct packed {
        logic            load_in;
        logic            push_we;
        logic            pop_we;
        logic            clr;
        logic            div_start;
        logic            dump_load;
        logic            dump_rd;
        logic            dump_dec;
        logic            emit;
        vsel_t           vsel;
        logic [ST_W-1:0] st;
        logic            last;
    } cmd_t;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic             clear;
        logic             cnt_zero;
        logic             cnt_one;
        logic             cnt_full;
        logic             right_zero;
        logic             idx_zero;
        logic             div_done;
        logic             out_free;
    } sts_t;

endpackage

@@ design/rpn_if.sv @@
interface rpn_in_if;
    logic                                valid;
    logic                                ready;
    logic [rpn_pkg::ACT_W-1:0]           action;
    logic signed [rpn_pkg::DATA_W-1:0]   operand;
    logic                                clear_request;

    modport source (output valid, action, operand, clear_request, input ready);
    modport sink   (input valid, action, operand, clear_request, output ready);
endinterface

interface rpn_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [rpn_pkg::DATA_W-1:0]   result_value;
    logic [rpn_pkg::ST_W-1:0]            status;
    logic                                last;

    modport source (output valid, result_value, status, last, input ready);
    modport sink   (input valid, result_value, status, last, output ready);
endinterface

@@ design/rpn_stack_calculator_core.sv @@
// channel | dir | beat payload                          | handshake
// item    | in  | action, operand, clear_request        | valid/ready
// res     | out | result_value, status, last            | valid/ready
//
// One item at a time. Push, add, subtract, multiply, peek, clear and errors
// give their result once the output register is free; divide first runs the
// iterative divider (one quotient bit per cycle); dump gives one result per
// stack entry (one registered stack read per entry). Reset clears the entry
// count and the output valid flag. A stalled result beat holds; the next
// item is accepted while the last result of the previous one waits.
module rpn_stack_calculator_core (
    input  logic     clk,
    input  logic     rst_n,
    rpn_in_if.sink   item,
    rpn_out_if.source res
);

    rpn_pkg::cmd_t cmd;
    rpn_pkg::sts_t sts;
    logic          in_ready;

    assign item.ready = in_ready;

    rpn_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item.valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    rpn_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .action        (item.action),
        .operand       (item.operand),
        .clear_request (item.clear_request),
        .res           (res),
        .sts           (sts)
    );

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (item.valid && item.ready) |=> !item.ready)
        else $error("item accepted while previous one in flight");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> sts.out_free)
        else $error("result overwritten before taken");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push_we |-> !sts.cnt_full)
        else $error("push on full stack");

    a_pop_ops: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.pop_we || cmd.div_start) |-> (!sts.cnt_zero && !sts.cnt_one))
        else $error("operator with fewer than two operands");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !sts.right_zero)
        else $error("divider started with zero divisor");

endmodule

@@ design/rpn_div.sv @@
module rpn_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [rpn_pkg::DATA_W-1:0] dividend,
    input  logic signed [rpn_pkg::DATA_W-1:0] divisor,
    output logic                              done,
    output logic [rpn_pkg::DATA_W-1:0]        quotient
);

    localparam int W      = rpn_pkg::DATA_W;
    localparam int ITER_W = $clog2(W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [ITER_W-1:0] iter_reg;
    logic [W-1:0]      rem_reg;
    logic [W-1:0]      quo_reg;
    logic [W-1:0]      md_reg;
    logic              neg_reg;
    logic [W:0]        shifted;
    logic [W:0]        trial;

    assign shifted = {rem_reg, quo_reg[W-1]};
    assign trial   = shifted - {1'b0, md_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
        end
        else if (busy_reg && (iter_reg == '0))
        begin
            busy_next = 1'b0;
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // restoring division on magnitudes, one quotient bit per cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            iter_reg <= ITER_W'(W - 1);
            rem_reg  <= '0;
            quo_reg  <= dividend[W-1] ? (W'(0) - dividend) : dividend;
            md_reg   <= divisor[W-1] ? (W'(0) - divisor) : divisor;
            neg_reg  <= dividend[W-1] ^ divisor[W-1];
        end
        else if (busy_reg)
        begin
            iter_reg <= iter_reg - ITER_W'(1);
            if (!trial[W])
            begin
                rem_reg <= trial[W-1:0];
                quo_reg <= {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[W-1:0];
                quo_reg <= {quo_reg[W-2:0], 1'b0};
            end
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (W'(0) - quo_reg) : quo_reg;

endmodule

@@ design/rpn_dp.sv @@
module rpn_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  rpn_pkg::cmd_t                     cmd,
    input  logic [rpn_pkg::ACT_W-1:0]         action,
    input  logic signed [rpn_pkg::DATA_W-1:0] operand,
    input  logic                              clear_request,
    rpn_out_if.source                         res,
    output rpn_pkg::sts_t                     sts
);

    localparam int W     = rpn_pkg::DATA_W;
    localparam int CNT_W = rpn_pkg::CNT_W;
    localparam int IDX_W = rpn_pkg::IDX_W;

    logic [W-1:0]     mem [rpn_pkg::DEPTH];

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic [IDX_W-1:0] idx_reg;
    logic [rpn_pkg::ACT_W-1:0] act_reg;
    logic             clr_reg;
    logic [W-1:0]     opnd_reg;
    logic [W-1:0]     rd_a_reg;
    logic [W-1:0]     rd_b_reg;
    logic [W-1:0]     out_value_reg;
    logic [rpn_pkg::ST_W-1:0] out_status_reg;
    logic             out_last_reg;

    logic [CNT_W-1:0] cnt_m1;
    logic [CNT_W-1:0] cnt_m2;
    logic [IDX_W-1:0] addr_a;
    logic [IDX_W-1:0] wr_addr;
    logic [W-1:0]     alu_val;
    logic [W-1:0]     sel_val;
    logic [W-1:0]     quo;
    logic             div_done;
    logic             out_free;

    assign cnt_m1 = cnt_reg - CNT_W'(1);
    assign cnt_m2 = cnt_reg - CNT_W'(2);
    assign addr_a = cmd.dump_rd ? idx_reg : cnt_m1[IDX_W-1:0];
    assign wr_addr = cmd.push_we ? cnt_reg[IDX_W-1:0] : cnt_m2[IDX_W-1:0];

    // rd_a holds the right operand (top), rd_b the left one
    always_comb
    begin
        case (act_reg)
            rpn_pkg::ACT_ADD: alu_val = rd_b_reg + rd_a_reg;
            rpn_pkg::ACT_SUB: alu_val = rd_b_reg - rd_a_reg;
            default:          alu_val = rd_b_reg * rd_a_reg;
        endcase
    end

    rpn_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (rd_b_reg),
        .divisor  (rd_a_reg),
        .done     (div_done),
        .quotient (quo)
    );

    always_comb
    begin
        unique case (cmd.vsel)
            rpn_pkg::VSEL_ZERO: sel_val = '0;
            rpn_pkg::VSEL_TOP:  sel_val = rd_a_reg;
            rpn_pkg::VSEL_OPND: sel_val = opnd_reg;
            rpn_pkg::VSEL_ALU:  sel_val = alu_val;
            rpn_pkg::VSEL_QUO:  sel_val = quo;
            default:            sel_val = '0;
        endcase
    end

    assign out_free = !out_valid_reg || res.ready;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.clr)
        begin
            cnt_next = '0;
        end
        else if (cmd.push_we)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (cmd.pop_we)
        begin
            cnt_next = cnt_m1;
        end

        out_valid_next = out_valid_reg;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            act_reg  <= action;
            clr_reg  <= clear_request;
            opnd_reg <= operand;
            rd_b_reg <= mem[cnt_m2[IDX_W-1:0]];
        end
        if (cmd.load_in || cmd.dump_rd)
        begin
            rd_a_reg <= mem[addr_a];
        end
        if (cmd.push_we || cmd.pop_we)
        begin
            mem[wr_addr] <= cmd.push_we ? opnd_reg : sel_val;
        end
        if (cmd.dump_load)
        begin
            idx_reg <= cnt_m1[IDX_W-1:0];
        end
        else if (cmd.dump_dec)
        begin
            idx_reg <= idx_reg - IDX_W'(1);
        end
        if (cmd.emit)
        begin
            out_value_reg  <= sel_val;
            out_status_reg <= cmd.st;
            out_last_reg   <= cmd.last;
        end
    end

    assign res.valid        = out_valid_reg;
    assign res.result_value = out_value_reg;
    assign res.status       = out_status_reg;
    assign res.last         = out_last_reg;

    assign sts.action     = act_reg;
    assign sts.clear      = clr_reg;
    assign sts.cnt_zero   = (cnt_reg == '0);
    assign sts.cnt_one    = (cnt_reg == CNT_W'(1));
    assign sts.cnt_full   = (cnt_reg >= CNT_W'(rpn_pkg::DEPTH));
    assign sts.right_zero = (rd_a_reg == '0);
    assign sts.idx_zero   = (idx_reg == '0);
    assign sts.div_done   = div_done;
    assign sts.out_free   = out_free;

endmodule

@@ design/rpn_ctrl.sv @@
module rpn_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  rpn_pkg::sts_t sts,
    output rpn_pkg::cmd_t cmd
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_EXEC     = 3'd1;
    localparam logic [2:0] S_DIV      = 3'd2;
    localparam logic [2:0] S_WB       = 3'd3;
    localparam logic [2:0] S_DUMP_RD  = 3'd4;
    localparam logic [2:0] S_DUMP_OUT = 3'd5;

    logic [2:0] state_reg, state_next;

    logic                      want;
    logic                      do_push;
    logic                      do_pop;
    logic                      do_clr;
    rpn_pkg::vsel_t            o_vsel;
    logic [rpn_pkg::ST_W-1:0]  o_st;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.vsel   = rpn_pkg::VSEL_ZERO;
        cmd.st     = rpn_pkg::ST_OK;
        want       = 1'b0;
        do_push    = 1'b0;
        do_pop     = 1'b0;
        do_clr     = 1'b0;
        o_vsel     = rpn_pkg::VSEL_ZERO;
        o_st       = rpn_pkg::ST_OK;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_EXEC;
                end
            end

            S_EXEC:
            begin
                if (sts.clear)
                begin
                    want   = 1'b1;
                    do_clr = 1'b1;
                end
                else
                begin
                    case (sts.action) inside
                        rpn_pkg::ACT_PUSH:
                        begin
                            want = 1'b1;
                            if (sts.cnt_full)
                            begin
                                o_vsel = rpn_pkg::VSEL_TOP;
                                o_st   = rpn_pkg::ST_FULL;
                            end
                            else
                            begin
                                o_vsel  = rpn_pkg::VSEL_OPND;
                                do_push = 1'b1;
                            end
                        end
                        rpn_pkg::ACT_ADD, rpn_pkg::ACT_SUB, rpn_pkg::ACT_MUL,
                        rpn_pkg::ACT_DIV:
                        begin
                            if (sts.cnt_zero)
                            begin
                                want = 1'b1;
                                o_st = rpn_pkg::ST_EMPTY;
                            end
                            else if (sts.cnt_one)
                            begin
                                want   = 1'b1;
                                o_vsel = rpn_pkg::VSEL_TOP;
                                o_st   = rpn_pkg::ST_ONE;
                            end
                            else if ((sts.action == rpn_pkg::ACT_DIV) && sts.right_zero)
                            begin
                                want   = 1'b1;
                                o_vsel = rpn_pkg::VSEL_TOP;
                                o_st   = rpn_pkg::ST_DIVZERO;
                            end
                            else if (sts.action == rpn_pkg::ACT_DIV)
                            begin
                                cmd.div_start = 1'b1;
                                state_next    = S_DIV;
                            end
                            else
                            begin
                                want   = 1'b1;
                                o_vsel = rpn_pkg::VSEL_ALU;
                                do_pop = 1'b1;
                            end
                        end
                        rpn_pkg::ACT_PEEK:
                        begin
                            want = 1'b1;
                            if (sts.cnt_zero)
                            begin
                                o_st = rpn_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                o_vsel = rpn_pkg::VSEL_TOP;
                            end
                        end
                        rpn_pkg::ACT_DUMP:
                        begin
                            if (sts.cnt_zero)
                            begin
                                want = 1'b1;
                                o_st = rpn_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                cmd.dump_load = 1'b1;
                                state_next    = S_DUMP_RD;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end

                // stack update commits together with the result beat
                if (want && sts.out_free)
                begin
                    cmd.emit    = 1'b1;
                    cmd.vsel    = o_vsel;
                    cmd.st      = o_st;
                    cmd.last    = 1'b1;
                    cmd.push_we = do_push;
                    cmd.pop_we  = do_pop;
                    cmd.clr     = do_clr;
                    state_next  = S_IDLE;
                end
            end

            S_DIV:
            begin
                if (sts.div_done)
                begin
                    state_next = S_WB;
                end
            end

            S_WB:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.vsel   = rpn_pkg::VSEL_QUO;
                    cmd.last   = 1'b1;
                    cmd.pop_we = 1'b1;
                    state_next = S_IDLE;
                end
            end

            S_DUMP_RD:
            begin
                cmd.dump_rd = 1'b1;
                state_next  = S_DUMP_OUT;
            end

            S_DUMP_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.vsel = rpn_pkg::VSEL_TOP;
                    cmd.last = sts.idx_zero;
                    if (sts.idx_zero)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.dump_dec = 1'b1;
                        state_next   = S_DUMP_RD;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
